// File: sv/dtc_pkg.sv
package dtc_pkg;

    // Widths of the fields of one request and one result.
    localparam int unsigned EPOCH_W  = 31;
    localparam int unsigned OFFSET_W = 5;
    localparam int unsigned YEAR_W   = 11;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned DAY_W    = 5;
    localparam int unsigned HOUR_W   = 5;
    localparam int unsigned MINUTE_W = 6;
    localparam int unsigned SECOND_W = 6;

    // Shared subtract unit width and the day count width (at most 24855 days).
    localparam int unsigned ALU_W  = 32;
    localparam int unsigned DAYS_W = 15;
    localparam int unsigned STEP_W = 4;

    localparam logic [ALU_W-1:0] DAY_SECS    = 32'd86400;
    localparam logic [ALU_W-1:0] HOUR_SECS   = 32'd3600;
    localparam logic [ALU_W-1:0] MINUTE_SECS = 32'd60;
    localparam logic [ALU_W-1:0] QUAD_DAYS   = 32'd1461;
    localparam logic [ALU_W-1:0] LEAP_DAYS   = 32'd366;
    localparam logic [ALU_W-1:0] YEAR_DAYS   = 32'd365;

    localparam logic [YEAR_W-1:0]  EPOCH_YEAR = 11'd1970;
    localparam logic [MONTH_W-1:0] JANUARY    = 4'd1;
    localparam logic [MONTH_W-1:0] FEBRUARY   = 4'd2;
    localparam logic [MONTH_W-1:0] APRIL      = 4'd4;
    localparam logic [MONTH_W-1:0] JUNE       = 4'd6;
    localparam logic [MONTH_W-1:0] SEPTEMBER  = 4'd9;
    localparam logic [MONTH_W-1:0] NOVEMBER   = 4'd11;
    localparam logic [MONTH_W-1:0] DECEMBER   = 4'd12;

    // Top quotient bit index of each division phase; the step counter counts down from it to zero.
    localparam logic [STEP_W-1:0] DAY_STEPS    = 4'd14;
    localparam logic [STEP_W-1:0] HOUR_STEPS   = 4'd4;
    localparam logic [STEP_W-1:0] MINUTE_STEPS = 4'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_DAY,
        S_DIV_HOUR,
        S_DIV_MIN,
        S_YEAR4,
        S_YEAR1,
        S_MONTH,
        S_DONE
    } dtc_state_t;

    typedef struct packed {
        logic [SECOND_W-1:0] second;
        logic [MINUTE_W-1:0] minute;
        logic [HOUR_W-1:0]   hour;
        logic [DAY_W-1:0]    day;
        logic [MONTH_W-1:0]  month;
        logic [YEAR_W-1:0]   year;
    } dtc_date_t;

    typedef struct packed {
        logic idle;
        logic done;
    } dtc_status_t;

    // Years reached here lie in 1970 .. 2038; the only century year among them,
    // 2000, is divisible by 400, so the full rule reduces to divisibility by 4.
    function automatic logic is_leap(input logic [YEAR_W-1:0] year);
        return (year[1:0] == 2'b00);
    endfunction

    function automatic logic [ALU_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                    input logic leap);
        logic [ALU_W-1:0] len;
        len = 32'd31;
        if ((month == APRIL) || (month == JUNE) || (month == SEPTEMBER) ||
            (month == NOVEMBER))
        begin
            len = 32'd30;
        end
        else if (month == FEBRUARY)
        begin
            len = leap ? 32'd29 : 32'd28;
        end
        return len;
    endfunction

endpackage

// File: sv/dtc_sub.sv
module dtc_sub
    import dtc_pkg::*;
(
    input  logic [ALU_W-1:0] a,
    input  logic [ALU_W-1:0] b,
    output logic [ALU_W-1:0] diff,
    output logic             ge
);

    logic [ALU_W:0] wide;

    // One subtractor serves every step; the borrow doubles as the compare.
    assign wide = {1'b0, a} - {1'b0, b};
    assign diff = wide[ALU_W-1:0];
    assign ge   = ~wide[ALU_W];

endmodule

// File: sv/dtc_core.sv
module dtc_core
    import dtc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [EPOCH_W-1:0]  count,
    input  logic                take,
    output dtc_status_t         status,
    output dtc_date_t           result
);

    dtc_state_t state_reg, state_next;

    logic [EPOCH_W-1:0]  rem_reg;
    logic [DAYS_W-2:0]   q_reg;
    logic [STEP_W-1:0]   k_reg;
    logic [DAYS_W-1:0]   days_reg;
    logic [YEAR_W-1:0]   year_reg;
    logic [MONTH_W-1:0]  month_reg;
    logic [HOUR_W-1:0]   hour_reg;
    logic [MINUTE_W-1:0] minute_reg;
    logic [SECOND_W-1:0] second_reg;

    logic [ALU_W-1:0] op_a;
    logic [ALU_W-1:0] op_b;
    logic [ALU_W-1:0] diff;
    logic             ge;
    logic             leap;

    assign leap = is_leap(year_reg);

    dtc_sub u_sub (
        .a    (op_a),
        .b    (op_b),
        .diff (diff),
        .ge   (ge)
    );

    // Operand selection for the shared subtractor.
    always_comb
    begin
        op_a = {{(ALU_W-DAYS_W){1'b0}}, days_reg};
        op_b = '0;
        case (state_reg)
            S_DIV_DAY:
            begin
                op_a = {1'b0, rem_reg};
                op_b = DAY_SECS << k_reg;
            end
            S_DIV_HOUR:
            begin
                op_a = {1'b0, rem_reg};
                op_b = HOUR_SECS << k_reg;
            end
            S_DIV_MIN:
            begin
                op_a = {1'b0, rem_reg};
                op_b = MINUTE_SECS << k_reg;
            end
            S_YEAR4: op_b = QUAD_DAYS;
            S_YEAR1: op_b = leap ? LEAP_DAYS : YEAR_DAYS;
            S_MONTH: op_b = month_days(month_reg, leap);
            default: op_b = '0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:     if (start) state_next = S_DIV_DAY;
            S_DIV_DAY:  if (k_reg == '0) state_next = S_DIV_HOUR;
            S_DIV_HOUR: if (k_reg == '0) state_next = S_DIV_MIN;
            S_DIV_MIN:  if (k_reg == '0) state_next = S_YEAR4;
            S_YEAR4:    if (!ge) state_next = S_YEAR1;
            S_YEAR1:    if (!ge) state_next = S_MONTH;
            S_MONTH:    if (!ge || (month_reg == DECEMBER)) state_next = S_DONE;
            S_DONE:     if (take) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        status.idle = (state_reg == S_IDLE);
        status.done = (state_reg == S_DONE);
    end

    assign result.year   = year_reg;
    assign result.month  = month_reg;
    assign result.day    = DAY_W'(days_reg) + DAY_W'(1);
    assign result.hour   = hour_reg;
    assign result.minute = minute_reg;
    assign result.second = second_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    rem_reg   <= count;
                    q_reg     <= '0;
                    k_reg     <= DAY_STEPS;
                    year_reg  <= EPOCH_YEAR;
                    month_reg <= JANUARY;
                end
            end
            S_DIV_DAY, S_DIV_HOUR, S_DIV_MIN:
            begin
                if (ge)
                begin
                    rem_reg <= diff[EPOCH_W-1:0];
                end
                q_reg <= {q_reg[DAYS_W-3:0], ge};
                k_reg <= k_reg - STEP_W'(1);
                if (k_reg == '0)
                begin
                    q_reg <= '0;
                    if (state_reg == S_DIV_DAY)
                    begin
                        days_reg <= {q_reg, ge};
                        k_reg    <= HOUR_STEPS;
                    end
                    else if (state_reg == S_DIV_HOUR)
                    begin
                        hour_reg <= {q_reg[HOUR_W-2:0], ge};
                        k_reg    <= MINUTE_STEPS;
                    end
                    else
                    begin
                        minute_reg <= {q_reg[MINUTE_W-2:0], ge};
                        second_reg <= ge ? diff[SECOND_W-1:0] : rem_reg[SECOND_W-1:0];
                    end
                end
            end
            S_YEAR4:
            begin
                if (ge)
                begin
                    days_reg <= diff[DAYS_W-1:0];
                    year_reg <= year_reg + YEAR_W'(4);
                end
            end
            S_YEAR1:
            begin
                if (ge)
                begin
                    days_reg <= diff[DAYS_W-1:0];
                    year_reg <= year_reg + YEAR_W'(1);
                end
            end
            S_MONTH:
            begin
                if (ge && (month_reg != DECEMBER))
                begin
                    days_reg  <= diff[DAYS_W-1:0];
                    month_reg <= month_reg + MONTH_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    a_hour_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV_HOUR) |-> ({1'b0, rem_reg} < DAY_SECS))
        else $error("remainder not below one day in hour phase");

    a_month_days: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MONTH) |-> ({{(ALU_W-DAYS_W){1'b0}}, days_reg} < LEAP_DAYS))
        else $error("day count exceeds one year in month phase");

    a_done_date: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |-> ((month_reg >= JANUARY) && (month_reg <= DECEMBER) &&
                                   (days_reg < DAYS_W'(31))))
        else $error("result date out of range");

endmodule

// File: sv/epoch_seconds_to_date.sv
// Channel   | Direction | Payload
// ----------+-----------+-------------------------------------------------------
// s_*       | in        | tdata[30:0] epoch_seconds, bit 31 zero
// m_*       | out       | tdata: year, month, day, hour, minute, second, 3 zero bits
// cfg_*     | in        | cfg_wdata[4:0] offset_hours, signed, written when cfg_we
//
// The shared subtractor works through each request in turn: a load in the idle state,
// 26 restoring-division steps, up to 18 four-year and 4 year steps, up to 12 month
// steps and the hand-over; the next request can be taken in the cycle after hand-over.
// Reset clears the control state and sets the offset to zero.
// While a request is in work s_tready is low; a finished result waits in the
// output register, and a new request is taken while it is not yet collected.
module epoch_seconds_to_date
    import dtc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [30:0] epoch_seconds, [31] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [10:0] year_out, [14:11] month_out, [19:15] day_out,
                                   // [24:20] hour_out, [30:25] minute_out,
                                   // [36:31] second_out, [39:37] zero
);

    logic signed [OFFSET_W-1:0] offset_reg;
    logic signed [17:0]         offset_secs;
    logic signed [32:0]         adjusted;
    logic [EPOCH_W-1:0]         clamped;

    dtc_status_t status;
    dtc_date_t   result;
    dtc_date_t   out_reg;
    logic        out_valid_reg;
    logic        start;
    logic        take;

    // The user writes the time zone offset only while the block is idle; the block does not enforce this.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
        end
        else if (cfg_we)
        begin
            offset_reg <= $signed(cfg_wdata);
        end
    end

    // The offset in seconds is added to the request, and the sum is clamped to
    // the range 0 .. 2^31-1 before the conversion starts.
    assign offset_secs = 18'(offset_reg) * 18'sd3600;
    assign adjusted    = $signed({2'b00, s_tdata[EPOCH_W-1:0]}) + 33'(offset_secs);

    always_comb
    begin
        if (adjusted[32])
        begin
            clamped = '0;
        end
        else if (adjusted[31])
        begin
            clamped = '1;
        end
        else
        begin
            clamped = adjusted[EPOCH_W-1:0];
        end
    end

    assign s_tready = status.idle;
    assign start    = s_tvalid && status.idle;

    // The sequencer hands its result over once the output register is free or
    // is being emptied in the same cycle.
    assign take = status.done && (!out_valid_reg || m_tready);

    dtc_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .count  (clamped),
        .take   (take),
        .status (status),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_reg};

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while previous one still in work");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (status.done && out_valid_reg && !m_tready) |=> status.done)
        else $error("result dropped while output register is full");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("waiting result changed before it was collected");

endmodule

// File: test/date_checker.sv
module date_checker
    import dtc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [4:0]        cfg_wdata,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [31:0]       s_tdata,    // [30:0] epoch_seconds, [31] zero
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [39:0]       m_tdata,    // [10:0] year, [14:11] month, [19:15] day,
                                          // [24:20] hour, [30:25] minute, [36:31] second
    output int unsigned       dates_checked,
    output int unsigned       mismatch_count
);

    localparam longint LAST_SECOND = 64'sd2147483647;

    logic signed [OFFSET_W-1:0] zone_hours;
    dtc_date_t                  pending_dates [$];

    function automatic bit leap_year(input int unsigned yr);
        return ((yr % 400) == 0) || (((yr % 100) != 0) && ((yr % 4) == 0));
    endfunction

    function automatic int unsigned month_length(input int unsigned mon, input bit leap);
        case (mon)
            4, 6, 9, 11: return 30;
            2:           return leap ? 29 : 28;
            default:     return 31;
        endcase
    endfunction

    // Full Gregorian conversion of the clamped, zone-shifted second count.
    function automatic dtc_date_t calendar_date(input logic [EPOCH_W-1:0] secs,
                                                input logic signed [OFFSET_W-1:0] hours);
        longint      shifted;
        longint      zone;
        int unsigned c;
        int unsigned days;
        int unsigned yr;
        int unsigned mon;
        int unsigned len;
        dtc_date_t   d;
        shifted = secs;
        zone    = hours;
        shifted = shifted + zone * 3600;
        if (shifted < 0)
        begin
            shifted = 0;
        end
        if (shifted > LAST_SECOND)
        begin
            shifted = LAST_SECOND;
        end
        c        = shifted[31:0];
        d.second = SECOND_W'(c % 60);
        c        = c / 60;
        d.minute = MINUTE_W'(c % 60);
        c        = c / 60;
        d.hour   = HOUR_W'(c % 24);
        days     = c / 24;
        yr  = 1970;
        len = leap_year(yr) ? 366 : 365;
        while (days >= len)
        begin
            days = days - len;
            yr   = yr + 1;
            len  = leap_year(yr) ? 366 : 365;
        end
        mon = 1;
        len = month_length(mon, leap_year(yr));
        while ((mon < 12) && (days >= len))
        begin
            days = days - len;
            mon  = mon + 1;
            len  = month_length(mon, leap_year(yr));
        end
        d.year  = YEAR_W'(yr);
        d.month = MONTH_W'(mon);
        d.day   = DAY_W'(days + 1);
        return d;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got, inout int unsigned errs);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errs++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        dtc_date_t   want;
        dtc_date_t   got;
        int unsigned errs;
        if (!rst_n)
        begin
            zone_hours     <= '0;
            pending_dates.delete();
            dates_checked  <= 0;
            mismatch_count <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                zone_hours <= cfg_wdata;
            end
            if (s_tvalid && s_tready)
            begin
                pending_dates.push_back(calendar_date(s_tdata[EPOCH_W-1:0], zone_hours));
            end
            if (m_tvalid && m_tready)
            begin
                got.year   = m_tdata[10:0];
                got.month  = m_tdata[14:11];
                got.day    = m_tdata[19:15];
                got.hour   = m_tdata[24:20];
                got.minute = m_tdata[30:25];
                got.second = m_tdata[36:31];
                if (pending_dates.size() == 0)
                begin
                    $error("result with no request outstanding: m_tdata %h", m_tdata);
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    want = pending_dates.pop_front();
                    errs = 0;
                    check_field("year_out", want.year, got.year, errs);
                    check_field("month_out", want.month, got.month, errs);
                    check_field("day_out", want.day, got.day, errs);
                    check_field("hour_out", want.hour, got.hour, errs);
                    check_field("minute_out", want.minute, got.minute, errs);
                    check_field("second_out", want.second, got.second, errs);
                    mismatch_count <= mismatch_count + errs;
                    dates_checked  <= dates_checked + 1;
                end
            end
        end
    end

endmodule

// File: test/epoch_seconds_to_date_tb.sv
module epoch_seconds_to_date_tb;
    import dtc_pkg::*;

    // A quiet stretch longer than this means the block has hung. The longest
    // legal quiet stretch is the long receiver hold plus one conversion.
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned LONG_HOLD      = 500;
    localparam int unsigned END_SETTLE     = 80;
    localparam int unsigned PHASE_COUNT    = 6;
    localparam int unsigned PHASE_ITEMS    = 185;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [4:0]  cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;    // [30:0] epoch_seconds, [31] zero
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;           // [10:0] year, [14:11] month, [19:15] day,
                                    // [24:20] hour, [30:25] minute, [36:31] second

    int unsigned dates_checked;
    int unsigned mismatch_count;
    int unsigned requests_sent = 0;

    // Idle bursts on the request and result sides can be switched off so that
    // some stretches, and the end of the run, go at full rate.
    bit          tx_gaps       = 1'b1;
    bit          rx_gaps       = 1'b1;
    int unsigned hold_requests = 0;
    int unsigned holds_served  = 0;

    // Calendar corners checked at the reset offset: minute, hour and day
    // rollovers, leap days of 1972 and 2000, year ends, alternating bit
    // patterns and the last representable second.
    int unsigned base_points [$] = {0, 59, 60, 3599, 3600, 86399, 86400,
                                    68169600, 94694399, 946684799, 951782400,
                                    951868799, 978307199, 2145916800,
                                    1431655765, 715827882, 2147483647};
    // With a -12 hour zone the first two fall below the zero clamp and the last lands at it.
    int unsigned west_points [$] = {0, 43199, 43200};
    // With a +14 hour zone these land below, at and beyond the upper clamp.
    int unsigned east_points [$] = {2147433246, 2147433247, 2147483647};

    always #1 clk = ~clk;

    epoch_seconds_to_date dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    date_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .dates_checked  (dates_checked),
        .mismatch_count (mismatch_count)
    );

    // Offer one request and hold it until the block takes it. Called right
    // after a rising edge, so every drive here is a single nonblocking update
    // per time step; valid stays high between back-to-back requests.
    task automatic send_request(input logic [EPOCH_W-1:0] secs);
        if (tx_gaps && ($urandom_range(0, 3) == 0))
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, secs};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        requests_sent++;
    endtask

    // Stop offering and wait until every accepted request has its result back.
    task automatic drain_requests();
        s_tvalid <= 1'b0;
        while (dates_checked != requests_sent)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // The offset register is only written while the block is idle.
    task automatic write_offset(input logic signed [OFFSET_W-1:0] hours);
        drain_requests();
        cfg_we    <= 1'b1;
        cfg_wdata <= hours;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Random second counts: mostly uniform, with extra weight near both ends
    // of the range and just around midnight of a random day.
    function automatic logic [EPOCH_W-1:0] pick_epoch();
        longint v;
        case ($urandom_range(0, 9))
            0:
            begin
                v = longint'($urandom_range(0, 200000));
            end
            1:
            begin
                v = 64'sd2147483647;
                v = v - longint'($urandom_range(0, 200000));
            end
            2, 3:
            begin
                v = longint'($urandom_range(0, 24855)) * 86400;
                v = v + longint'($urandom_range(0, 4)) - 2;
            end
            default:
            begin
                v = longint'($urandom & 32'h7FFF_FFFF);
            end
        endcase
        if (v < 0)
        begin
            v = 0;
        end
        if (v > 64'sd2147483647)
        begin
            v = 64'sd2147483647;
        end
        return v[EPOCH_W-1:0];
    endfunction

    // Result side: random stall bursts, plus a long hold whenever the
    // stimulus asks for one. The hold is timed here so the sender keeps
    // offering requests and the block backs up onto its input.
    initial
    begin : result_sink
        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            if (holds_served != hold_requests)
            begin
                holds_served++;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (rx_gaps && ($urandom_range(0, 5) == 0))
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
        end
    end

    // Ends the run if neither channel moves for too long.
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin : stimulus
        int phase_hours [PHASE_COUNT];
        phase_hours = '{-16, 15, 0, 7, -5, 0};
        phase_hours[PHASE_COUNT-1] = $urandom_range(0, 31);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners, first at the offset left by reset.
        foreach (base_points[i])
        begin
            send_request(base_points[i][EPOCH_W-1:0]);
        end
        write_offset(-5'sd12);
        foreach (west_points[i])
        begin
            send_request(west_points[i][EPOCH_W-1:0]);
        end
        write_offset(5'sd14);
        foreach (east_points[i])
        begin
            send_request(east_points[i][EPOCH_W-1:0]);
        end

        // Random phases, each under its own zone offset. The two extremes of
        // the 5-bit register come first, out-of-range values included.
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            write_offset(phase_hours[p][OFFSET_W-1:0]);
            // One middle phase and the final phase run without any idling.
            tx_gaps = (p != 2) && (p != PHASE_COUNT - 1);
            rx_gaps = tx_gaps;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ((p == 3) && (n == 20))
                begin
                    hold_requests <= hold_requests + 1;
                end
                if ((p == 4) && (n == 90))
                begin
                    // Sender pauses until the block has nothing outstanding.
                    drain_requests();
                end
                send_request(pick_epoch());
            end
        end

        drain_requests();
        repeat (END_SETTLE) @(posedge clk);
        if ((mismatch_count == 0) && (dates_checked == requests_sent))
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
